### rtl/core/mtcg_pkg.sv
// Shared widths, codes, register indexes and stage payload types for the cell pixel generator.
`timescale 1ns / 1ps
`default_nettype none
package mtcg_pkg;

  // Field widths
  localparam int LINE_W     = 9;
  localparam int COL_W      = 7;
  localparam int ATTR_W     = 8;
  localparam int GLYPH_W    = 9;
  localparam int X_W        = 10;
  localparam int CODE_W     = 2;
  localparam int ROW_W      = 6;   // pixel lines / smallest cell height
  localparam int SCAN_W     = 5;
  localparam int OFFSET_W   = 13;  // row * columns + column at full width
  localparam int CURSOR_W   = 11;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 11;

  // Parameter defaults
  localparam int CELL_HEIGHT_DEF  = 14;
  localparam int CELL_WIDTH_DEF   = 9;
  localparam int TEXT_COLUMNS_DEF = 80;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_BLINK_ENABLE      = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_CURSOR_CELL       = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_CURSOR_FIRST_LINE = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_CURSOR_LAST_LINE  = 2'd3;

  // Register reset values
  localparam logic [SCAN_W-1:0] CURSOR_FIRST_RST = 5'd11;
  localparam logic [SCAN_W-1:0] CURSOR_LAST_RST  = 5'd12;

  // Colour codes
  localparam logic [CODE_W-1:0] CODE_BG      = 2'd0;
  localparam logic [CODE_W-1:0] CODE_FG      = 2'd1;
  localparam logic [CODE_W-1:0] CODE_INTENSE = 2'd2;

  // Attribute nibble patterns
  localparam logic [2:0] ATTR_NORMAL    = 3'h7;
  localparam logic [2:0] ATTR_INVERSE   = 3'h0;
  localparam logic [2:0] ATTR_UNDERLINE = 3'h1;

  localparam logic [SCAN_W-1:0] UNDERLINE_LINE = 5'd12;

  typedef struct packed {
    logic                blink_enable;
    logic [CURSOR_W-1:0] cursor_cell;
    logic [SCAN_W-1:0]   cursor_first_line;
    logic [SCAN_W-1:0]   cursor_last_line;
  } cfg_t;

  // Decode stage result: row and scan line split, attribute resolved
  typedef struct packed {
    logic [LINE_W-1:0]  pixel_line;
    logic [ROW_W-1:0]   row;
    logic [SCAN_W-1:0]  scan;
    logic [COL_W-1:0]   column;
    logic [GLYPH_W-1:0] glyph_row;
    logic [CODE_W-1:0]  fg_code;
    logic [CODE_W-1:0]  bg_code;
    logic               underline;
    logic               cursor_shown;
  } dec_t;

  // Finished cell, ready to be split into pixels
  typedef struct packed {
    logic [LINE_W-1:0]  pixel_line;
    logic [X_W-1:0]     x_base;
    logic [GLYPH_W-1:0] bitmap;
    logic [CODE_W-1:0]  fg_code;
    logic [CODE_W-1:0]  bg_code;
    logic               cursor_here;
  } cell_t;

endpackage
`default_nettype wire

### rtl/core/mtcg_intf.sv
// Request channel interfaces: cell input, pixel output and register write.
`timescale 1ns / 1ps
`default_nettype none
interface mtcg_cell_if;
  logic                         valid;
  logic                         ready;
  logic [mtcg_pkg::LINE_W-1:0]  pixel_line;
  logic [mtcg_pkg::COL_W-1:0]   column;
  logic [mtcg_pkg::ATTR_W-1:0]  attribute;
  logic [mtcg_pkg::GLYPH_W-1:0] glyph_row;
  logic                         blink_phase_on;
  logic                         cursor_shown;

  modport source (output valid, pixel_line, column, attribute, glyph_row, blink_phase_on,
                  cursor_shown, input ready);
  modport sink   (input valid, pixel_line, column, attribute, glyph_row, blink_phase_on,
                  cursor_shown, output ready);
endinterface

interface mtcg_pixel_if;
  logic                        valid;
  logic                        ready;
  logic [mtcg_pkg::X_W-1:0]    pixel_x;
  logic [mtcg_pkg::LINE_W-1:0] pixel_y;
  logic [mtcg_pkg::CODE_W-1:0] color_code;
  logic                        last;

  modport source (output valid, pixel_x, pixel_y, color_code, last, input ready);
  modport sink   (input valid, pixel_x, pixel_y, color_code, last, output ready);
endinterface

interface mtcg_cfg_if;
  logic                            valid;
  logic                            ready;
  logic [mtcg_pkg::CFG_IDX_W-1:0]  index;
  logic [mtcg_pkg::CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface
`default_nettype wire

### rtl/core/mtcg_decode.sv
// Two stages: line split by reciprocal multiply with one correction, attribute decode.
`timescale 1ns / 1ps
`default_nettype none
module mtcg_decode #(
  parameter int CELL_HEIGHT = mtcg_pkg::CELL_HEIGHT_DEF
) (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire mtcg_pkg::cfg_t               cfg,
  input  wire logic                         up_valid,
  output logic                              up_ready,
  input  wire logic [mtcg_pkg::LINE_W-1:0]  pixel_line,
  input  wire logic [mtcg_pkg::COL_W-1:0]   column,
  input  wire logic [mtcg_pkg::ATTR_W-1:0]  attribute,
  input  wire logic [mtcg_pkg::GLYPH_W-1:0] glyph_row,
  input  wire logic                         blink_phase_on,
  input  wire logic                         cursor_shown,
  output logic                              dn_valid,
  input  wire logic                         dn_ready,
  output mtcg_pkg::dec_t                    dn_data
);

  localparam int RECIP_SHIFT = 16;
  localparam int RECIP       = (1 << RECIP_SHIFT) / CELL_HEIGHT;
  localparam int PROD_W      = mtcg_pkg::LINE_W + RECIP_SHIFT + 1;

  // Stage 1 registers
  logic                         s1_valid_r;
  logic [mtcg_pkg::LINE_W-1:0]  s1_line_r;
  logic [mtcg_pkg::ROW_W-1:0]   s1_quot_r;
  logic [mtcg_pkg::COL_W-1:0]   s1_col_r;
  logic [mtcg_pkg::GLYPH_W-1:0] s1_glyph_r;
  logic [mtcg_pkg::CODE_W-1:0]  s1_fg_r;
  logic [mtcg_pkg::CODE_W-1:0]  s1_bg_r;
  logic                         s1_ul_r;
  logic                         s1_cshown_r;
  logic                         s1_ready;

  // Stage 2 registers
  logic                         s2_valid_r;
  mtcg_pkg::dec_t               s2_data_r;
  logic                         s2_ready;

  logic [PROD_W-1:0]            prod;
  logic [mtcg_pkg::CODE_W-1:0]  fg_nxt;
  logic [mtcg_pkg::CODE_W-1:0]  bg_nxt;
  logic                         ul_nxt;
  logic [2:0]                   bg_bits;
  logic [2:0]                   fg_bits;

  logic [mtcg_pkg::LINE_W-1:0]  qh;
  logic [mtcg_pkg::LINE_W-1:0]  rem;
  logic                         rem_over;
  mtcg_pkg::dec_t               s2_data_nxt;

  assign s2_ready = !s2_valid_r || dn_ready;
  assign s1_ready = !s1_valid_r || s2_ready;
  assign up_ready = s1_ready;

  // Quotient estimate, at most one low
  assign prod = PROD_W'(pixel_line) * PROD_W'(RECIP);

  assign bg_bits = attribute[6:4];
  assign fg_bits = attribute[2:0];

  always_comb begin
    fg_nxt = attribute[3] ? mtcg_pkg::CODE_INTENSE : mtcg_pkg::CODE_FG;
    bg_nxt = mtcg_pkg::CODE_BG;
    ul_nxt = 1'b0;
    priority if (bg_bits == mtcg_pkg::ATTR_NORMAL && fg_bits == mtcg_pkg::ATTR_INVERSE) begin
      fg_nxt = mtcg_pkg::CODE_BG;
      bg_nxt = mtcg_pkg::CODE_FG;
    end else if (bg_bits == mtcg_pkg::ATTR_INVERSE && fg_bits == mtcg_pkg::ATTR_INVERSE) begin
      fg_nxt = mtcg_pkg::CODE_BG;
    end else if (bg_bits == mtcg_pkg::ATTR_INVERSE && fg_bits == mtcg_pkg::ATTR_UNDERLINE) begin
      ul_nxt = 1'b1;
    end else begin
      ul_nxt = 1'b0;
    end
    // Hidden blink phase: drop the glyph and the underline
    if (attribute[7] && cfg.blink_enable && !blink_phase_on) begin
      fg_nxt = bg_nxt;
      ul_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (s1_ready) begin
      s1_valid_r <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_valid && s1_ready) begin
      s1_line_r   <= pixel_line;
      s1_quot_r   <= prod[RECIP_SHIFT +: mtcg_pkg::ROW_W];
      s1_col_r    <= column;
      s1_glyph_r  <= glyph_row;
      s1_fg_r     <= fg_nxt;
      s1_bg_r     <= bg_nxt;
      s1_ul_r     <= ul_nxt;
      s1_cshown_r <= cursor_shown;
    end
  end

  // Correct the estimate with one compare and subtract
  assign qh       = mtcg_pkg::LINE_W'(32'(s1_quot_r) * CELL_HEIGHT);
  assign rem      = s1_line_r - qh;
  assign rem_over = rem >= mtcg_pkg::LINE_W'(CELL_HEIGHT);

  always_comb begin
    s2_data_nxt.pixel_line   = s1_line_r;
    s2_data_nxt.row          = rem_over ? mtcg_pkg::ROW_W'(s1_quot_r + 1'b1) : s1_quot_r;
    s2_data_nxt.scan         = rem_over ? mtcg_pkg::SCAN_W'(rem - mtcg_pkg::LINE_W'(CELL_HEIGHT))
                                        : mtcg_pkg::SCAN_W'(rem);
    s2_data_nxt.column       = s1_col_r;
    s2_data_nxt.glyph_row    = s1_glyph_r;
    s2_data_nxt.fg_code      = s1_fg_r;
    s2_data_nxt.bg_code      = s1_bg_r;
    s2_data_nxt.underline    = s1_ul_r;
    s2_data_nxt.cursor_shown = s1_cshown_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_valid_r <= 1'b0;
    end else if (s2_ready) begin
      s2_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_valid_r && s2_ready) begin
      s2_data_r <= s2_data_nxt;
    end
  end

  assign dn_valid = s2_valid_r;
  assign dn_data  = s2_data_r;

endmodule
`default_nettype wire

### rtl/core/mtcg_locate.sv
// Two stages: cell offset and underline rule, then cursor match.
`timescale 1ns / 1ps
`default_nettype none
module mtcg_locate #(
  parameter int CELL_WIDTH   = mtcg_pkg::CELL_WIDTH_DEF,
  parameter int TEXT_COLUMNS = mtcg_pkg::TEXT_COLUMNS_DEF
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire mtcg_pkg::cfg_t       cfg,
  input  wire logic                 up_valid,
  output logic                      up_ready,
  input  wire mtcg_pkg::dec_t       up_data,
  output logic                      dn_valid,
  input  wire logic                 dn_ready,
  output mtcg_pkg::cell_t           dn_data
);

  // Stage 3 registers
  logic                          s3_valid_r;
  logic [mtcg_pkg::OFFSET_W-1:0] s3_offset_r;
  logic [mtcg_pkg::SCAN_W-1:0]   s3_scan_r;
  logic                          s3_cshown_r;
  mtcg_pkg::cell_t               s3_cell_r;
  logic                          s3_ready;

  // Stage 4 registers
  logic                          s4_valid_r;
  mtcg_pkg::cell_t               s4_cell_r;
  logic                          s4_ready;

  mtcg_pkg::cell_t               s3_cell_nxt;
  logic [mtcg_pkg::OFFSET_W-1:0] offset_nxt;
  mtcg_pkg::cell_t               s4_cell_nxt;
  logic                          hit;

  assign s4_ready = !s4_valid_r || dn_ready;
  assign s3_ready = !s3_valid_r || s4_ready;
  assign up_ready = s3_ready;

  assign offset_nxt = mtcg_pkg::OFFSET_W'(up_data.row) * mtcg_pkg::OFFSET_W'(TEXT_COLUMNS)
                    + mtcg_pkg::OFFSET_W'(up_data.column);

  always_comb begin
    s3_cell_nxt.pixel_line  = up_data.pixel_line;
    s3_cell_nxt.x_base      = mtcg_pkg::X_W'(32'(up_data.column) * CELL_WIDTH);
    // Underline rule fills the whole scan line
    s3_cell_nxt.bitmap      = (up_data.scan == mtcg_pkg::UNDERLINE_LINE && up_data.underline)
                              ? '1 : up_data.glyph_row;
    s3_cell_nxt.fg_code     = up_data.fg_code;
    s3_cell_nxt.bg_code     = up_data.bg_code;
    s3_cell_nxt.cursor_here = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s3_valid_r <= 1'b0;
    end else if (s3_ready) begin
      s3_valid_r <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_valid && s3_ready) begin
      s3_offset_r <= offset_nxt;
      s3_scan_r   <= up_data.scan;
      s3_cshown_r <= up_data.cursor_shown;
      s3_cell_r   <= s3_cell_nxt;
    end
  end

  assign hit = s3_cshown_r
            && s3_offset_r == mtcg_pkg::OFFSET_W'(cfg.cursor_cell)
            && s3_scan_r >= cfg.cursor_first_line
            && s3_scan_r <= cfg.cursor_last_line;

  always_comb begin
    s4_cell_nxt             = s3_cell_r;
    s4_cell_nxt.cursor_here = hit;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s4_valid_r <= 1'b0;
    end else if (s4_ready) begin
      s4_valid_r <= s3_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s3_valid_r && s4_ready) begin
      s4_cell_r <= s4_cell_nxt;
    end
  end

  assign dn_valid = s4_valid_r;
  assign dn_data  = s4_cell_r;

endmodule
`default_nettype wire

### rtl/core/mtcg_serial.sv
// Cell register and pixel counter: emits one pixel a cycle unless stalled, left to right.
`timescale 1ns / 1ps
`default_nettype none
module mtcg_serial #(
  parameter int CELL_WIDTH = mtcg_pkg::CELL_WIDTH_DEF
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        up_valid,
  output logic                             up_ready,
  input  wire mtcg_pkg::cell_t             up_data,
  output logic                             pix_valid,
  input  wire logic                        pix_ready,
  output logic [mtcg_pkg::X_W-1:0]         pix_x,
  output logic [mtcg_pkg::LINE_W-1:0]      pix_y,
  output logic [mtcg_pkg::CODE_W-1:0]      pix_code,
  output logic                             pix_last
);

  localparam int IDX_W = $clog2(CELL_WIDTH);
  localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(CELL_WIDTH - 1);

  logic                 cell_valid_r;
  mtcg_pkg::cell_t      cell_r;
  logic [IDX_W-1:0]     idx_r;
  logic [IDX_W-1:0]     sel;
  logic                 bit_on;
  logic                 take;

  assign pix_last = idx_r == IDX_LAST;
  assign take     = pix_valid && pix_ready;
  // Load the next cell as the last pixel of this one leaves
  assign up_ready = !cell_valid_r || (take && pix_last);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cell_valid_r <= 1'b0;
      idx_r        <= '0;
    end else begin
      if (up_ready) begin
        cell_valid_r <= up_valid;
      end
      if (take) begin
        idx_r <= pix_last ? '0 : IDX_W'(idx_r + 1'b1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (up_valid && up_ready) begin
      cell_r <= up_data;
    end
  end

  assign sel    = IDX_LAST - idx_r;
  assign bit_on = cell_r.bitmap[sel];

  assign pix_valid = cell_valid_r;
  assign pix_x     = mtcg_pkg::X_W'(cell_r.x_base + mtcg_pkg::X_W'(idx_r));
  assign pix_y     = cell_r.pixel_line;
  assign pix_code  = cell_r.cursor_here ? mtcg_pkg::CODE_FG
                   : (bit_on ? cell_r.fg_code : cell_r.bg_code);

endmodule
`default_nettype wire

### rtl/core/mda_text_cell_pixel_generator_top.sv
// Top level of the MDA text cell pixel generator: registers, pipeline and pixel output.
//
//   Channel  Direction  Moves
//   in_if    sink       one cell request per scan line (line, column, attribute, glyph row)
//   out_if   source     one pixel request (x, y, colour code, last)
//   cfg_if   sink       register write (index, data); always ready
//
// A cell passes four register stages (line split, row correction, offset, cursor
// match) and then the pixel register, which emits CELL_WIDTH pixels at one per cycle.
// Throughput is set by the single pixel output port: the pixel register loads the next
// cell only as the last pixel of the current one leaves.
// Reset (rst_n low, synchronous) empties every stage and loads the register defaults.
// A stall on out_if holds the current pixel; the stages behind it fill and then hold.
`timescale 1ns / 1ps
`default_nettype none
module mda_text_cell_pixel_generator_top #(
  parameter int CELL_HEIGHT  = mtcg_pkg::CELL_HEIGHT_DEF,
  parameter int CELL_WIDTH   = mtcg_pkg::CELL_WIDTH_DEF,
  parameter int TEXT_COLUMNS = mtcg_pkg::TEXT_COLUMNS_DEF
) (
  input  wire logic     clk,
  input  wire logic     rst_n,
  mtcg_cell_if.sink     in_if,
  mtcg_pixel_if.source  out_if,
  mtcg_cfg_if.sink      cfg_if
);

  mtcg_pkg::cfg_t  cfg_r;
  logic            dec_valid;
  logic            dec_ready;
  mtcg_pkg::dec_t  dec_data;
  logic            loc_valid;
  logic            loc_ready;
  mtcg_pkg::cell_t loc_data;

  assign cfg_if.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.blink_enable      <= 1'b1;
      cfg_r.cursor_cell       <= '0;
      cfg_r.cursor_first_line <= mtcg_pkg::CURSOR_FIRST_RST;
      cfg_r.cursor_last_line  <= mtcg_pkg::CURSOR_LAST_RST;
    end else if (cfg_if.valid) begin
      unique case (cfg_if.index)
        mtcg_pkg::REG_BLINK_ENABLE:      cfg_r.blink_enable      <= cfg_if.data[0];
        mtcg_pkg::REG_CURSOR_CELL:       cfg_r.cursor_cell       <= cfg_if.data;
        mtcg_pkg::REG_CURSOR_FIRST_LINE: cfg_r.cursor_first_line <=
                                           cfg_if.data[mtcg_pkg::SCAN_W-1:0];
        mtcg_pkg::REG_CURSOR_LAST_LINE:  cfg_r.cursor_last_line  <=
                                           cfg_if.data[mtcg_pkg::SCAN_W-1:0];
      endcase
    end
  end

  mtcg_decode #(
    .CELL_HEIGHT (CELL_HEIGHT)
  ) u_decode (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg            (cfg_r),
    .up_valid       (in_if.valid),
    .up_ready       (in_if.ready),
    .pixel_line     (in_if.pixel_line),
    .column         (in_if.column),
    .attribute      (in_if.attribute),
    .glyph_row      (in_if.glyph_row),
    .blink_phase_on (in_if.blink_phase_on),
    .cursor_shown   (in_if.cursor_shown),
    .dn_valid       (dec_valid),
    .dn_ready       (dec_ready),
    .dn_data        (dec_data)
  );

  mtcg_locate #(
    .CELL_WIDTH   (CELL_WIDTH),
    .TEXT_COLUMNS (TEXT_COLUMNS)
  ) u_locate (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg      (cfg_r),
    .up_valid (dec_valid),
    .up_ready (dec_ready),
    .up_data  (dec_data),
    .dn_valid (loc_valid),
    .dn_ready (loc_ready),
    .dn_data  (loc_data)
  );

  mtcg_serial #(
    .CELL_WIDTH (CELL_WIDTH)
  ) u_serial (
    .clk       (clk),
    .rst_n     (rst_n),
    .up_valid  (loc_valid),
    .up_ready  (loc_ready),
    .up_data   (loc_data),
    .pix_valid (out_if.valid),
    .pix_ready (out_if.ready),
    .pix_x     (out_if.pixel_x),
    .pix_y     (out_if.pixel_y),
    .pix_code  (out_if.color_code),
    .pix_last  (out_if.last)
  );

`ifndef SYNTHESIS
  // Within a cell the next pixel follows at once, one column to the right
  a_pixel_step: assert property (@(posedge clk) disable iff (!rst_n)
    out_if.valid && out_if.ready && !out_if.last |=>
      out_if.valid && out_if.pixel_x == mtcg_pkg::X_W'($past(out_if.pixel_x) + 1'b1))
    else $error("pixel sequence broken inside a cell");

  // Line stays fixed across the pixels of one cell
  a_line_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_if.valid && out_if.ready && !out_if.last |=> $stable(out_if.pixel_y))
    else $error("pixel line changed inside a cell");

  a_code_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_if.valid |-> out_if.color_code == mtcg_pkg::CODE_BG
                  || out_if.color_code == mtcg_pkg::CODE_FG
                  || out_if.color_code == mtcg_pkg::CODE_INTENSE)
    else $error("colour code out of range");
`endif

endmodule
`default_nettype wire
